/* hw/rtl/dsv_pkg.sv */
// shared widths and direction table for the direction/speed velocity block
`timescale 1ns / 1ps
`default_nettype none

package dsv_pkg;

  localparam int DELTA_WIDTH = 16;
  localparam int SPEED_WIDTH = 8;
  localparam int VEL_WIDTH   = 9;
  localparam int ENTRY_WIDTH = 8;
  localparam int QUOT_WIDTH  = 4;
  localparam int PROD_WIDTH  = SPEED_WIDTH + ENTRY_WIDTH;
  // holds 15 * min, and the divisor shifted up by three
  localparam int REM_WIDTH   = DELTA_WIDTH + QUOT_WIDTH;
  localparam int OUT_SHIFT   = 7;

  localparam int S_TDATA_WIDTH = 2 * DELTA_WIDTH + SPEED_WIDTH;
  localparam int S_TDATA_BYTES = (S_TDATA_WIDTH + 7) / 8;
  localparam int M_TDATA_WIDTH = 2 * VEL_WIDTH;
  localparam int M_TDATA_BYTES = (M_TDATA_WIDTH + 7) / 8;

  // index is {scaled y, scaled x}
  localparam logic [ENTRY_WIDTH-1:0] DIR_TABLE_X [256] = '{
     90,128,128,128,128,128,128,128,128,128,128,128,128,128,128,128,
      0, 90,114,121,124,125,126,126,127,127,127,127,127,127,127,127,
      0, 57, 90,106,114,118,121,123,124,124,125,125,126,126,126,126,
      0, 40, 71, 90,102,109,114,117,119,121,122,123,124,124,125,125,
      0, 31, 57, 76, 90, 99,106,111,114,116,118,120,121,122,123,123,
      0, 25, 47, 65, 79, 90, 98,104,108,111,114,116,118,119,120,121,
      0, 21, 40, 57, 71, 81, 90, 97,102,106,109,112,114,116,117,118,
      0, 18, 35, 50, 63, 74, 83, 90, 96,101,104,107,110,112,114,115,
      0, 15, 31, 44, 57, 67, 76, 84, 90, 95, 99,103,106,109,111,112,
      0, 14, 27, 40, 51, 62, 71, 78, 85, 90, 95, 99,102,105,107,109,
      0, 12, 25, 36, 47, 57, 65, 73, 79, 85, 90, 94, 98,101,104,106,
      0, 11, 22, 33, 43, 52, 61, 68, 75, 81, 86, 90, 94, 97,100,103,
      0, 10, 21, 31, 40, 49, 57, 64, 71, 76, 81, 86, 90, 94, 97, 99,
      0,  9, 19, 28, 37, 45, 53, 60, 67, 72, 78, 82, 86, 90, 93, 96,
      0,  9, 18, 26, 35, 43, 50, 57, 63, 69, 74, 79, 83, 87, 90, 93,
      0,  8, 16, 25, 32, 40, 47, 54, 60, 65, 71, 75, 79, 83, 87, 90
  };

  localparam logic [ENTRY_WIDTH-1:0] DIR_TABLE_Y [256] = '{
     90,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,  0,
    128, 90, 57, 40, 31, 25, 21, 18, 15, 14, 12, 11, 10,  9,  9,  8,
    128,114, 90, 71, 57, 47, 40, 35, 31, 27, 25, 22, 21, 19, 18, 16,
    128,121,106, 90, 76, 65, 57, 50, 44, 40, 36, 33, 31, 28, 26, 25,
    128,124,114,102, 90, 79, 71, 63, 57, 51, 47, 43, 40, 37, 35, 32,
    128,125,118,109, 99, 90, 81, 74, 67, 62, 57, 52, 49, 45, 43, 40,
    128,126,121,114,106, 98, 90, 83, 76, 71, 65, 61, 57, 53, 50, 47,
    128,126,123,117,111,104, 97, 90, 84, 78, 73, 68, 64, 60, 57, 54,
    128,127,124,119,114,108,102, 96, 90, 85, 79, 75, 71, 67, 63, 60,
    128,127,124,121,116,111,106,101, 95, 90, 85, 81, 76, 72, 69, 65,
    128,127,125,122,118,114,109,104, 99, 95, 90, 86, 81, 78, 74, 71,
    128,127,125,123,120,116,112,107,103, 99, 94, 90, 86, 82, 79, 75,
    128,127,126,124,121,118,114,110,106,102, 98, 94, 90, 86, 83, 79,
    128,127,126,124,122,119,116,112,109,105,101, 97, 94, 90, 87, 83,
    128,127,126,125,123,120,117,114,111,107,104,100, 97, 93, 90, 87,
    128,127,126,125,123,121,118,115,112,109,106,103, 99, 96, 93, 90
  };

endpackage

`default_nettype wire

/* hw/rtl/direction_speed_vector_top.sv */
// direction/speed to velocity vector, six-stage pipeline with stream ports
`timescale 1ns / 1ps
`default_nettype none

// Takes a signed direction (delta_x, delta_y) and an unsigned speed and returns a
// velocity (vel_x, vel_y) of roughly that magnitude. The larger magnitude of the two
// direction components always scales to 15; the smaller one becomes
// floor(15*min/max), found by a four-step restoring division split over two
// stages. The pair addresses a 256-entry direction table, and each table byte is
// multiplied by the speed and shifted down by 7, flooring for negative components
// (a zero component counts as positive). A zero direction gives a zero velocity.
// The pipeline accepts one item every cycle while the result port is not stalled;
// each result passes through the six register stages (magnitude, compare,
// two division stages, table and multiply, sign and shift).
// Back-pressure on the result port stalls all stages together, so no item is
// dropped or repeated. There is no state beyond the pipeline itself.
module direction_speed_vector_top import dsv_pkg::*; (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // delta_x [15:0], delta_y [31:16], speed [39:32]
  input  wire [8*S_TDATA_BYTES-1:0]   s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  // vel_x [8:0], vel_y [17:9], zero fill above
  output logic [8*M_TDATA_BYTES-1:0]  m_axis_tdata_o
);

  // whole pipeline moves when the output register is free or being taken
  logic adv;
  assign adv             = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && adv;

  // unpack the input item
  logic [DELTA_WIDTH-1:0] delta_x, delta_y;
  logic [SPEED_WIDTH-1:0] speed;
  assign delta_x = s_axis_tdata_i[DELTA_WIDTH-1:0];
  assign delta_y = s_axis_tdata_i[2*DELTA_WIDTH-1:DELTA_WIDTH];
  assign speed   = s_axis_tdata_i[2*DELTA_WIDTH+SPEED_WIDTH-1:2*DELTA_WIDTH];

  // ---------------- stage 1: magnitudes and signs ----------------
  logic                   v1_q;
  logic [DELTA_WIDTH-1:0] ax1_q, ay1_q;
  logic                   nx1_q, ny1_q;
  logic [SPEED_WIDTH-1:0] spd1_q;
  logic [DELTA_WIDTH-1:0] ax1_d, ay1_d;

  // most negative input gives 2^(DELTA_WIDTH-1), exact as unsigned
  assign ax1_d = delta_x[DELTA_WIDTH-1] ? (~delta_x + 1'b1) : delta_x;
  assign ay1_d = delta_y[DELTA_WIDTH-1] ? (~delta_y + 1'b1) : delta_y;

  // ---------------- stage 2: max/min, dividend 15*min ----------------
  logic                   v2_q;
  logic [REM_WIDTH-1:0]   rem2_q;
  logic [DELTA_WIDTH-1:0] max2_q;
  logic                   xbig2_q, zero2_q;
  logic                   nx2_q, ny2_q;
  logic [SPEED_WIDTH-1:0] spd2_q;
  logic                   xbig2_d;
  logic [DELTA_WIDTH-1:0] max2_d, min2_d;
  logic [REM_WIDTH-1:0]   rem2_d;

  assign xbig2_d = ax1_q >= ay1_q;
  assign max2_d  = xbig2_d ? ax1_q : ay1_q;
  assign min2_d  = xbig2_d ? ay1_q : ax1_q;
  assign rem2_d  = (REM_WIDTH'(min2_d) << QUOT_WIDTH) - REM_WIDTH'(min2_d);

  // ---------------- stage 3: quotient bits 3 and 2 ----------------
  logic                   v3_q;
  logic [REM_WIDTH-1:0]   rem3_q;
  logic [1:0]             qhi3_q;
  logic [DELTA_WIDTH-1:0] max3_q;
  logic                   xbig3_q, zero3_q;
  logic                   nx3_q, ny3_q;
  logic [SPEED_WIDTH-1:0] spd3_q;
  logic [REM_WIDTH-1:0]   dv2, r3a, rem3_d;
  logic [1:0]             qhi3_d;

  assign dv2 = REM_WIDTH'(max2_q);

  always_comb begin
    r3a = rem2_q;
    qhi3_d = '0;
    if (r3a >= (dv2 << 3)) begin
      r3a = r3a - (dv2 << 3);
      qhi3_d[1] = 1'b1;
    end
    rem3_d = r3a;
    if (r3a >= (dv2 << 2)) begin
      rem3_d = r3a - (dv2 << 2);
      qhi3_d[0] = 1'b1;
    end
  end

  // ---------------- stage 4: quotient bits 1 and 0 ----------------
  logic                   v4_q;
  logic [QUOT_WIDTH-1:0]  sx4_q, sy4_q;
  logic                   zero4_q;
  logic                   nx4_q, ny4_q;
  logic [SPEED_WIDTH-1:0] spd4_q;
  logic [REM_WIDTH-1:0]   dv3, r4a;
  logic [1:0]             qlo4;
  logic [QUOT_WIDTH-1:0]  q4;

  assign dv3 = REM_WIDTH'(max3_q);

  always_comb begin
    r4a  = rem3_q;
    qlo4 = '0;
    if (r4a >= (dv3 << 1)) begin
      r4a = r4a - (dv3 << 1);
      qlo4[1] = 1'b1;
    end
    if (r4a >= dv3) begin
      qlo4[0] = 1'b1;
    end
  end

  assign q4 = {qhi3_q, qlo4};

  // ---------------- stage 5: table lookup and multiply ----------------
  logic                   v5_q;
  logic [PROD_WIDTH-1:0]  px5_q, py5_q;
  logic                   zero5_q;
  logic                   nx5_q, ny5_q;
  logic [7:0]             tab_idx;
  logic [ENTRY_WIDTH-1:0] ex5, ey5;

  assign tab_idx = {sy4_q, sx4_q};
  assign ex5     = DIR_TABLE_X[tab_idx];
  assign ey5     = DIR_TABLE_Y[tab_idx];

  // ---------------- stage 6: sign, floor shift, output register ----------------
  logic [VEL_WIDTH-1:0]  vx6_d, vy6_d;
  logic [VEL_WIDTH-1:0]  vel_x_q, vel_y_q;
  logic [PROD_WIDTH-1:0] cx6, cy6;

  // floor of a negative product over 128 is minus its ceiling
  assign cx6 = px5_q + PROD_WIDTH'((1 << OUT_SHIFT) - 1);
  assign cy6 = py5_q + PROD_WIDTH'((1 << OUT_SHIFT) - 1);

  always_comb begin
    vx6_d = nx5_q ? (VEL_WIDTH'(0) - cx6[OUT_SHIFT+VEL_WIDTH-1:OUT_SHIFT])
                  : px5_q[OUT_SHIFT+VEL_WIDTH-1:OUT_SHIFT];
    vy6_d = ny5_q ? (VEL_WIDTH'(0) - cy6[OUT_SHIFT+VEL_WIDTH-1:OUT_SHIFT])
                  : py5_q[OUT_SHIFT+VEL_WIDTH-1:OUT_SHIFT];
    if (zero5_q) begin
      vx6_d = '0;
      vy6_d = '0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      v3_q            <= 1'b0;
      v4_q            <= 1'b0;
      v5_q            <= 1'b0;
      m_axis_tvalid_o <= 1'b0;
    end else if (adv) begin
      v1_q            <= s_acc;
      v2_q            <= v1_q;
      v3_q            <= v2_q;
      v4_q            <= v3_q;
      v5_q            <= v4_q;
      m_axis_tvalid_o <= v5_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax1_q   <= ax1_d;
      ay1_q   <= ay1_d;
      nx1_q   <= delta_x[DELTA_WIDTH-1];
      ny1_q   <= delta_y[DELTA_WIDTH-1];
      spd1_q  <= speed;

      rem2_q  <= rem2_d;
      max2_q  <= max2_d;
      xbig2_q <= xbig2_d;
      zero2_q <= (max2_d == '0);
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      spd2_q  <= spd1_q;

      rem3_q  <= rem3_d;
      qhi3_q  <= qhi3_d;
      max3_q  <= max2_q;
      xbig3_q <= xbig2_q;
      zero3_q <= zero2_q;
      nx3_q   <= nx2_q;
      ny3_q   <= ny2_q;
      spd3_q  <= spd2_q;

      // larger component always scales to 15
      sx4_q   <= xbig3_q ? {QUOT_WIDTH{1'b1}} : q4;
      sy4_q   <= xbig3_q ? q4 : {QUOT_WIDTH{1'b1}};
      zero4_q <= zero3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      spd4_q  <= spd3_q;

      px5_q   <= spd4_q * ex5;
      py5_q   <= spd4_q * ey5;
      zero5_q <= zero4_q;
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;

      vel_x_q <= vx6_d;
      vel_y_q <= vy6_d;
    end
  end

  assign m_axis_tdata_o = {{(8*M_TDATA_BYTES-M_TDATA_WIDTH){1'b0}}, vel_y_q, vel_x_q};

endmodule

`default_nettype wire

/* verif/testbench.sv */
// self-checking stream testbench for the direction/speed velocity block
`timescale 1ns / 1ps

module testbench import dsv_pkg::*; ();

  localparam int PIPE_LATENCY = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [SPEED_WIDTH-1:0]        speed;
    logic signed [DELTA_WIDTH-1:0] dy;
    logic signed [DELTA_WIDTH-1:0] dx;
  } heading_t;

  typedef struct packed {
    logic signed [VEL_WIDTH-1:0] vel_y;
    logic signed [VEL_WIDTH-1:0] vel_x;
  } velocity_t;

  typedef struct {
    heading_t  cause;
    velocity_t vel;
  } vel_expect_t;

  // edge of the heading table where the larger component scales to 15;
  // the table is symmetric, so the row and the column share these bytes
  localparam logic [7:0] EDGE_MINOR [16] = '{
    0, 8, 16, 25, 32, 40, 47, 54, 60, 65, 71, 75, 79, 83, 87, 90
  };
  localparam logic [7:0] EDGE_MAJOR [16] = '{
    128, 127, 126, 125, 123, 121, 118, 115, 112, 109, 106, 103, 99, 96, 93, 90
  };

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [8*S_TDATA_BYTES-1:0] s_axis_tdata = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [8*M_TDATA_BYTES-1:0] m_axis_tdata;

  vel_expect_t pending_vel[$];
  int          mismatch_count = 0;
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  logic        rx_hold = 1'b0;

  direction_speed_vector_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [VEL_WIDTH-1:0] scale_axis(logic [7:0] spd,
                                                             logic [7:0] entry, bit neg);
    int prod;
    int r;
    prod = int'(spd) * int'(entry);
    // negative products floor, so round the magnitude up before negating
    r = neg ? -((prod + 127) >>> 7) : (prod >>> 7);
    return r[VEL_WIDTH-1:0];
  endfunction

  function automatic velocity_t predict_velocity(heading_t h);
    int        ax;
    int        ay;
    int        m;
    int        qx;
    int        qy;
    logic [7:0] ex;
    logic [7:0] ey;
    velocity_t v;
    ax = (h.dx < 0) ? -int'(h.dx) : int'(h.dx);
    ay = (h.dy < 0) ? -int'(h.dy) : int'(h.dy);
    m  = (ax > ay) ? ax : ay;
    if (m == 0) begin
      return '0;
    end
    qx = (15 * ax) / m;
    qy = (15 * ay) / m;
    if (qy == 15) begin
      ex = EDGE_MINOR[qx[3:0]];
      ey = EDGE_MAJOR[qx[3:0]];
    end else begin
      ex = EDGE_MAJOR[qy[3:0]];
      ey = EDGE_MINOR[qy[3:0]];
    end
    v.vel_x = scale_axis(h.speed, ex, h.dx < 0);
    v.vel_y = scale_axis(h.speed, ey, h.dy < 0);
    return v;
  endfunction

  function automatic heading_t heading(int dx, int dy, int spd);
    heading_t h;
    h.dx    = dx[DELTA_WIDTH-1:0];
    h.dy    = dy[DELTA_WIDTH-1:0];
    h.speed = spd[SPEED_WIDTH-1:0];
    return h;
  endfunction

  function automatic heading_t random_heading();
    int       big;
    int       minor;
    int       sel;
    heading_t h;
    h.dx = DELTA_WIDTH'($urandom);
    h.dy = DELTA_WIDTH'($urandom);
    case ($urandom_range(9))
      4, 5: begin
        // small directions reach every scaled column
        h.dx = DELTA_WIDTH'(int'($urandom_range(40)) - 20);
        h.dy = DELTA_WIDTH'(int'($urandom_range(40)) - 20);
      end
      6: begin
        sel  = $urandom_range(4);
        h.dx = DELTA_WIDTH'((sel == 0) ? -32768 : (sel == 1) ? 32767 :
                            (sel == 2) ? 0 : (sel == 3) ? 1 : -1);
        sel  = $urandom_range(4);
        h.dy = DELTA_WIDTH'((sel == 0) ? -32768 : (sel == 1) ? 32767 :
                            (sel == 2) ? 0 : (sel == 3) ? 1 : -1);
      end
      7: begin
        // aim at a chosen ratio between the two components
        big   = $urandom_range(32767, 1);
        minor = $urandom_range(big);
        if ($urandom_range(1)) begin
          h.dx = DELTA_WIDTH'(big);
          h.dy = DELTA_WIDTH'(minor);
        end else begin
          h.dx = DELTA_WIDTH'(minor);
          h.dy = DELTA_WIDTH'(big);
        end
        if ($urandom_range(1)) h.dx = -h.dx;
        if ($urandom_range(1)) h.dy = -h.dy;
      end
      8: begin
        h.dy = $urandom_range(1) ? h.dx : -h.dx;
      end
      9: begin
        if ($urandom_range(1)) h.dx = '0;
        else h.dy = '0;
      end
      default: begin
      end
    endcase
    sel = $urandom_range(9);
    h.speed = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom);
    return h;
  endfunction

  // offer one item, with random idle cycles ahead of it, and log its result
  task automatic send_heading(heading_t h);
    vel_expect_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= (8*S_TDATA_BYTES)'(h);
    do @(posedge clk_i); while (!s_axis_tready);
    e.cause = h;
    e.vel   = predict_velocity(h);
    pending_vel.push_back(e);
  endtask

  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    while (pending_vel.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_pct = 18;
    snk_idle_pct <= 47;
    // zero direction
    send_heading(heading(0, 0, 255));
    send_heading(heading(0, 0, 0));
    // axes and most negative components
    send_heading(heading(32767, 0, 255));
    send_heading(heading(-32768, 0, 255));
    send_heading(heading(0, -32768, 255));
    send_heading(heading(-32768, -32768, 255));
    send_heading(heading(32767, -32768, 255));
    send_heading(heading(-32768, 32767, 1));
    // a zero component keeps a positive sign
    send_heading(heading(0, -5, 200));
    send_heading(heading(-5, 0, 200));
    // diagonals and flooring of negative results
    send_heading(heading(1, -1, 255));
    send_heading(heading(-1, -1, 1));
    send_heading(heading(-1, 2, 3));
    send_heading(heading(3, -7, 255));
    send_heading(heading(100, -33, 128));
    send_heading(heading(-32767, 16384, 77));
    send_heading(heading(1, 15, 255));
    send_heading(heading(-15, -1, 129));
    send_heading(heading(32767, 32767, 0));
    send_heading(heading(2, -30000, 255));
    // alternating bit patterns on all fields
    send_heading(heading(21845, -21846, 170));
    send_heading(heading(-21846, 21845, 85));
    await_results();
  endtask

  task automatic test_random(int count, int src_pct, int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct <= snk_pct;
    repeat (count) send_heading(random_heading());
    await_results();
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      begin
        repeat (60) send_heading(random_heading());
      end
    join
    await_results();
  endtask

  // sender goes quiet until the pipeline has emptied, then resumes
  task automatic test_pause();
    src_idle_pct = 0;
    snk_idle_pct <= 18;
    repeat (20) send_heading(random_heading());
    await_results();
    repeat (20) send_heading(random_heading());
    await_results();
  endtask

  // result check and receiver ready
  always @(posedge clk_i) begin
    vel_expect_t             e;
    logic [VEL_WIDTH-1:0]    got_x;
    logic [VEL_WIDTH-1:0]    got_y;
    logic [8*M_TDATA_BYTES-1:2*VEL_WIDTH] fill;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[VEL_WIDTH-1:0];
      got_y = m_axis_tdata[2*VEL_WIDTH-1:VEL_WIDTH];
      fill  = m_axis_tdata[8*M_TDATA_BYTES-1:2*VEL_WIDTH];
      if (pending_vel.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result: vel_x=%0d vel_y=%0d",
                   $signed(got_x), $signed(got_y));
        end
      end else begin
        e = pending_vel.pop_front();
        if (got_x !== e.vel.vel_x || got_y !== e.vel.vel_y || fill !== '0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display({"mismatch: dx=%0d dy=%0d speed=%0d ",
                      "expected (%0d,%0d) got (%0d,%0d) fill %h"},
                     e.cause.dx, e.cause.dy, e.cause.speed, e.vel.vel_x, e.vel.vel_y,
                     $signed(got_x), $signed(got_y), fill);
          end
        end
      end
    end
    m_axis_tready <= rst_ni && !rx_hold && ($urandom_range(99) >= snk_idle_pct);
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(500, 18, 47);
    test_random(500, 47, 18);
    test_random(500, 0, 0);
    test_backpressure();
    test_pause();
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/dsv_pkg.sv
hw/rtl/direction_speed_vector_top.sv
verif/testbench.sv
